/* src/abnsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annex-B NAL splitter package
// Shared widths, defaults and byte codes for the start-code NAL splitter.
// ----------------------------------------------------------------------------
package abnsp_pkg;

	localparam int unsigned MAX_RANGES_DEF = 4096;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 32;
	localparam int unsigned IDX_W  = 12;
	localparam int unsigned ZR_W   = 2;

	// byte values that make up a start code
	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

	// zero-run counter saturates here
	localparam logic [ZR_W-1:0] ZR_MAX = 2'd3;

endpackage

/* src/annexb_nal_unit_splitter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annex-B NAL unit splitter, top level
// Finds 00 00 01 start codes in a byte stream and reports each NAL payload
// as an offset / length / index request, one byte accepted per cycle unless the result channel stalls.
// ----------------------------------------------------------------------------
// Pipeline: a byte accepted into the input register is decoded there, and its
//   result, if any, is captured in the result register (two register stages).
// Throughput: one byte per cycle while out_stall does not hold a full result
//   register; one decode pass (32-bit position adders) sits between the registers.
// Reset: arst_n clears valid_s1 and out_valid (not range_valid) and the stream
//   state (position, payload start, zero run, inside flag, unit count); the last
//   byte also returns the stream state to these values.
module annexb_nal_unit_splitter_top #(
	parameter int unsigned MAX_RANGES = abnsp_pkg::MAX_RANGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// byte input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [abnsp_pkg::BYTE_W-1:0]    data_byte,
	input  logic                            last_byte,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [abnsp_pkg::POS_W-1:0]     range_offset,
	output logic [abnsp_pkg::POS_W-1:0]     range_length,
	output logic [abnsp_pkg::IDX_W-1:0]     range_index,
	output logic                            range_valid,
	output logic                            end_of_stream
);

	// unit counter must hold MAX_RANGES itself (saturation point)
	localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_RANGES);

	// ------------------------------------------------------------------
	// Input register stage
	// ------------------------------------------------------------------
	logic                           valid_s1;
	logic [abnsp_pkg::BYTE_W-1:0]   byte_s1;
	logic                           last_s1;

	// stream state
	logic [abnsp_pkg::POS_W-1:0]    byte_position_q;
	logic [abnsp_pkg::POS_W-1:0]    payload_start_q;
	logic [abnsp_pkg::ZR_W-1:0]     zero_run_q;
	logic                           inside_payload_q;
	logic [CNT_W-1:0]               range_count_q;

	// result register
	logic                           out_valid_q;
	logic [abnsp_pkg::POS_W-1:0]    offset_q;
	logic [abnsp_pkg::POS_W-1:0]    length_q;
	logic [abnsp_pkg::IDX_W-1:0]    index_q;
	logic                           rvalid_q;
	logic                           eos_q;

	// the stage-1 byte moves on whenever the result register is free or
	// being drained this cycle
	logic advance;
	logic fire;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	// hold the input while the decoded byte cannot move on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// ------------------------------------------------------------------
	// Decode pass
	// ------------------------------------------------------------------
	logic                           is_zero;
	logic                           start_code;
	logic [abnsp_pkg::POS_W-1:0]    pos_next;
	logic [abnsp_pkg::POS_W-1:0]    sc_end;
	logic [abnsp_pkg::POS_W-1:0]    sc_len;
	logic                           count_ok;
	logic                           have_sc;
	logic                           inside_next;
	logic [abnsp_pkg::POS_W-1:0]    pstart_next;
	logic [abnsp_pkg::ZR_W-1:0]     zero_run_next;
	logic [abnsp_pkg::POS_W-1:0]    tail_len;
	logic                           have_tail;
	logic                           emit;
	logic [abnsp_pkg::POS_W-1:0]    count_wide;

	assign is_zero    = (byte_s1 == abnsp_pkg::BYTE_ZERO);
	// two or more zeros followed by 01 completes a start code
	assign start_code = (byte_s1 == abnsp_pkg::BYTE_ONE) && zero_run_q[1];
	assign pos_next   = byte_position_q + abnsp_pkg::POS_W'(1);

	// drop the start code and, with three zeros seen, the leading zero too
	assign sc_end   = byte_position_q - ((zero_run_q == abnsp_pkg::ZR_MAX)
	                  ? abnsp_pkg::POS_W'(3) : abnsp_pkg::POS_W'(2));
	assign sc_len   = sc_end - payload_start_q;
	assign count_ok = (range_count_q < CNT_LIMIT);
	assign have_sc  = start_code && inside_payload_q && (sc_len != '0) && count_ok;

	assign inside_next = inside_payload_q || start_code;
	assign pstart_next = start_code ? pos_next : payload_start_q;

	always_comb begin
		priority if (start_code) begin
			zero_run_next = '0;
		end else if (is_zero) begin
			zero_run_next = (zero_run_q == abnsp_pkg::ZR_MAX) ? zero_run_q
			                : zero_run_q + abnsp_pkg::ZR_W'(1);
		end else begin
			zero_run_next = '0;
		end
	end

	// the last byte closes the open payload when no start code did
	assign tail_len  = pos_next - pstart_next;
	assign have_tail = last_s1 && !have_sc && inside_next && (tail_len != '0) && count_ok;

	assign emit       = fire && (have_sc || last_s1);
	assign count_wide = abnsp_pkg::POS_W'(range_count_q);

	// ------------------------------------------------------------------
	// Stream state: advance per decoded byte, clear after the last one
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			payload_start_q  <= '0;
			zero_run_q       <= '0;
			inside_payload_q <= 1'b0;
			range_count_q    <= '0;
		end else if (fire) begin
			if (last_s1) begin
				byte_position_q  <= '0;
				payload_start_q  <= '0;
				zero_run_q       <= '0;
				inside_payload_q <= 1'b0;
				range_count_q    <= '0;
			end else begin
				byte_position_q  <= pos_next;
				payload_start_q  <= pstart_next;
				zero_run_q       <= zero_run_next;
				inside_payload_q <= inside_next;
				if (have_sc) begin
					range_count_q <= range_count_q + CNT_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rvalid_q <= have_sc || have_tail;
			eos_q    <= last_s1;
			priority if (have_sc) begin
				offset_q <= payload_start_q;
				length_q <= sc_len;
				index_q  <= count_wide[abnsp_pkg::IDX_W-1:0];
			end else if (have_tail) begin
				offset_q <= pstart_next;
				length_q <= tail_len;
				index_q  <= count_wide[abnsp_pkg::IDX_W-1:0];
			end else begin
				offset_q <= '0;
				length_q <= '0;
				index_q  <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign range_offset  = offset_q;
	assign range_length  = length_q;
	assign range_index   = index_q;
	assign range_valid   = rvalid_q;
	assign end_of_stream = eos_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// unit count never passes its saturation point
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		range_count_q <= CNT_LIMIT)
		else $error("unit count above limit");

	// a decoded last byte leaves the stream state at its reset values
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> byte_position_q == '0 && !inside_payload_q
		&& range_count_q == '0)
		else $error("stream state not cleared after last byte");

	// a result without a unit carries zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rvalid_q |-> offset_q == '0 && length_q == '0 && eos_q)
		else $error("empty result with non-zero fields");

	// a reported unit is never empty
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rvalid_q |-> length_q != '0)
		else $error("empty unit reported");

endmodule

/* test/tb_annexb_nal_unit_splitter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Annex-B NAL unit splitter
// Streams bytes into the splitter and predicts every offset / length / index
// request it should report. Hand-made streams cover the start code corners.
// Random streams mix start codes, zero runs and noise. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_annexb_nal_unit_splitter_top;

	localparam int unsigned UNIT_LIMIT  = abnsp_pkg::MAX_RANGES_DEF;
	localparam int unsigned RANDOM_BYTES = 1600;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned MAX_REPORTS  = 10;

	// one reported NAL range, as seen on the result channel
	typedef struct packed {
		logic [abnsp_pkg::POS_W-1:0] offset;
		logic [abnsp_pkg::POS_W-1:0] length;
		logic [abnsp_pkg::IDX_W-1:0] index;
		logic                        valid;
		logic                        eos;
	} nal_range_t;

	// ------------------------------------------------------------------------
	// Range predictor and store of pending ranges
	// ------------------------------------------------------------------------
	class nal_range_board;
		logic [abnsp_pkg::POS_W-1:0] position;
		logic [abnsp_pkg::POS_W-1:0] unit_start;
		logic [abnsp_pkg::ZR_W-1:0]  zeros_seen;
		bit                          in_unit;
		int unsigned                 unit_count;
		int unsigned                 unit_ceiling;
		nal_range_t                  pending[$];
		int unsigned                 mismatches;
		int unsigned                 checked;
		int unsigned                 units_seen;
		int unsigned                 streams_seen;

		function new(int unsigned ceiling);
			unit_ceiling = ceiling;
			mismatches   = 0;
			checked      = 0;
			units_seen   = 0;
			streams_seen = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			position   = '0;
			unit_start = '0;
			zeros_seen = '0;
			in_unit    = 1'b0;
			unit_count = 0;
		endfunction

		// Advance the stream state by one accepted byte; queue any range it closes.
		function void note_byte(logic [abnsp_pkg::BYTE_W-1:0] b, bit last);
			logic [abnsp_pkg::POS_W-1:0] here;
			logic [abnsp_pkg::POS_W-1:0] stop;
			logic [abnsp_pkg::POS_W-1:0] len;
			nal_range_t                  r;
			here = position;
			r    = '0;
			if (b == abnsp_pkg::BYTE_ONE && zeros_seen >= 2) begin
				// start code ends here: close the open unit, minus the code's zeros and any trailing zero
				if (in_unit) begin
					stop = here - ((zeros_seen == abnsp_pkg::ZR_MAX) ? 32'd3 : 32'd2);
					len  = stop - unit_start;
					if (len != 0 && unit_count < unit_ceiling) begin
						r.valid  = 1'b1;
						r.offset = unit_start;
						r.length = len;
						r.index  = unit_count[abnsp_pkg::IDX_W-1:0];
						unit_count++;
					end
				end
				in_unit    = 1'b1;
				unit_start = here + 1;
				zeros_seen = '0;
			end else if (b == abnsp_pkg::BYTE_ZERO) begin
				if (zeros_seen != abnsp_pkg::ZR_MAX)
					zeros_seen++;
			end else begin
				zeros_seen = '0;
			end
			position = here + 1;
			if (last) begin
				// the final byte closes the open unit unless a start code just did
				if (!r.valid && in_unit) begin
					len = position - unit_start;
					if (len != 0 && unit_count < unit_ceiling) begin
						r.valid  = 1'b1;
						r.offset = unit_start;
						r.length = len;
						r.index  = unit_count[abnsp_pkg::IDX_W-1:0];
					end
				end
				r.eos = 1'b1;
				pending.push_back(r);
				streams_seen++;
				clear_stream();
			end else if (r.valid) begin
				pending.push_back(r);
			end
		endfunction

		// Compare one accepted request with the oldest pending range.
		function void check_range(nal_range_t got);
			nal_range_t want;
			checked++;
			if (got.valid)
				units_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected range off=%0d len=%0d idx=%0d vld=%0b eos=%0b",
						$realtime, got.offset, got.length, got.index, got.valid, got.eos);
				return;
			end
			want = pending.pop_front();
			if (got.offset !== want.offset || got.length !== want.length ||
			    got.index !== want.index || got.valid !== want.valid ||
			    got.eos !== want.eos) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("[%0t] range mismatch #%0d", $realtime, mismatches);
					$display("  expected off=%0d len=%0d idx=%0d vld=%0b eos=%0b",
						want.offset, want.length, want.index, want.valid, want.eos);
					$display("  actual   off=%0d len=%0d idx=%0d vld=%0b eos=%0b",
						got.offset, got.length, got.index, got.valid, got.eos);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block ports
	// ------------------------------------------------------------------------
	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic [abnsp_pkg::BYTE_W-1:0] data_byte  = '0;
	logic                         last_byte  = 1'b0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic [abnsp_pkg::POS_W-1:0]  range_offset;
	logic [abnsp_pkg::POS_W-1:0]  range_length;
	logic [abnsp_pkg::IDX_W-1:0]  range_index;
	logic                         range_valid;
	logic                         end_of_stream;

	always #6 clk = ~clk;

	annexb_nal_unit_splitter_top #(
		.MAX_RANGES(UNIT_LIMIT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.range_offset (range_offset),
		.range_length (range_length),
		.range_index  (range_index),
		.range_valid  (range_valid),
		.end_of_stream(end_of_stream)
	);

	nal_range_board               board;
	logic [abnsp_pkg::BYTE_W-1:0] stream_bytes[$];
	bit                           calm = 1'b0;
	int unsigned                  cycles = 0;
	int unsigned                  bytes_sent = 0;

	// Idle with a 38 percent chance, except while the calm stretch runs.
	function automatic bit take_gap();
		return !calm && ($urandom_range(0, 99) < 38);
	endfunction

	// ------------------------------------------------------------------------
	// Result side: stall at random, check every accepted request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_stall <= take_gap();
	end

	always @(posedge clk) begin : result_monitor
		nal_range_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.offset = range_offset;
			got.length = range_length;
			got.index  = range_index;
			got.valid  = range_valid;
			got.eos    = end_of_stream;
			board.check_range(got);
		end
	end

	// Give up well past the slowest plausible run.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d ranges pending", cycles,
				board.pending.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Byte side
	// ------------------------------------------------------------------------
	// Offer one byte, hold it while stalled, note it once it is taken.
	task automatic send_byte(logic [abnsp_pkg::BYTE_W-1:0] b, bit last);
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do begin
			@(posedge clk);
		end while (in_stall);
		board.note_byte(b, last);
		bytes_sent++;
	endtask

	// Send the staged stream, flagging its final byte.
	task automatic play_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
	endtask

	// Pick one stream element: a start code, a zero or a one in 47 of 100 picks, else noise.
	task automatic add_random_piece();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			if ($urandom_range(0, 2) == 0)
				stream_bytes.push_back(abnsp_pkg::BYTE_ZERO);
			stream_bytes.push_back(abnsp_pkg::BYTE_ZERO);
			stream_bytes.push_back(abnsp_pkg::BYTE_ZERO);
			stream_bytes.push_back(abnsp_pkg::BYTE_ONE);
		end else if (pick < 40) begin
			stream_bytes.push_back(abnsp_pkg::BYTE_ZERO);
		end else if (pick < 47) begin
			stream_bytes.push_back(abnsp_pkg::BYTE_ONE);
		end else begin
			stream_bytes.push_back(abnsp_pkg::BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int unsigned span;
		board = new(UNIT_LIMIT);

		// hold reset, then release once and for all
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed streams ---
		// lone byte before any start code
		stream_bytes = '{8'hFF};
		play_stream();
		// final byte completes a start code with nothing before it
		stream_bytes = '{8'h00, 8'h00, 8'h01};
		play_stream();
		// two units, the second closed by the final byte
		stream_bytes = '{8'h80, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h7F,
			8'h00, 8'h00, 8'h01, 8'h55};
		play_stream();
		// four-byte codes; the final byte is a start code that closes a unit
		stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00,
			8'h00, 8'h00, 8'h01};
		play_stream();
		// empty unit between back-to-back codes, then a single zero kept
		stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h01, 8'hFE, 8'h00};
		play_stream();

		// --- random streams: mostly small, a few long ---
		while (bytes_sent < RANDOM_BYTES) begin
			// hold a stretch of the run free of idle cycles on both sides
			calm = (bytes_sent > 700 && bytes_sent < 1000);
			span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 30);
			stream_bytes.delete();
			while (stream_bytes.size() < span)
				add_random_piece();
			play_stream();
		end
		calm = 1'b0;

		// a short stream at the end shows the count starts over
		stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h3C, 8'hC3};
		play_stream();
		in_valid <= 1'b0;

		// drain every pending range, then let the pipeline settle
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d streams; %0d requests checked, %0d valid units.",
			bytes_sent, board.streams_seen, board.checked, board.units_seen);
		$display("Covered split and four-byte start codes, empty units, random stalls.");
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d ranges left", board.mismatches,
				board.pending.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
